@@ rtl/assert_macros.svh @@
// Assertion macros shared by the ultrasonic echo ranger RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is high
`define UER_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that must also hold during reset
`define UER_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/uer_pkg.sv @@
// Types and constants for the ultrasonic echo ranger
`default_nettype none

package uer_pkg;

  // Input word kinds
  typedef enum logic [1:0] {
    FUNC_TRIGGER = 2'd0,
    FUNC_EDGE    = 2'd1,
    FUNC_POLL    = 2'd2
  } func_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRESH_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd2;

  // Configuration reset values
  localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd60;
  localparam logic [15:0] FRESH_WINDOW_RST = 16'd200;
  localparam logic [15:0] MAX_DISTANCE_RST = 16'd4000;

  // mm = (width * 343) / 2000, done as ((width * 343) >> 4) / 125.
  // The divide by 125 is a multiply by ceil(2^35 / 125) and a shift by 35,
  // exact for every 28-bit dividend.
  localparam int            DIV_SHIFT = 35;
  localparam int            QUO_W     = 22;
  localparam logic [28:0]   DIV_RECIP = 29'd274877907;

  typedef struct packed {
    logic [15:0] echo_timeout_ms;
    logic [15:0] fresh_window_ms;
    logic [15:0] max_distance_mm;
  } cfg_t;

  typedef struct packed {
    func_t       func;
    logic        echo_line;
    logic        echo_level;
    logic [31:0] now_ms;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic [15:0] distance_mm;
    logic        distance_valid;
    logic        distance_fresh;
    logic        pulse_started;
    logic        busy_res;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/uer_cfg.sv @@
// Configuration register file of the ultrasonic echo ranger
`default_nettype none

module uer_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                cfg_data,
  output uer_pkg::cfg_t                   cfg
);
  import uer_pkg::*;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_timeout_ms <= ECHO_TIMEOUT_RST;
      cfg.fresh_window_ms <= FRESH_WINDOW_RST;
      cfg.max_distance_mm <= MAX_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ECHO_TIMEOUT: cfg.echo_timeout_ms <= cfg_data;
        CFG_FRESH_WINDOW: cfg.fresh_window_ms <= cfg_data;
        CFG_MAX_DISTANCE: cfg.max_distance_mm <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/uer_dist.sv @@
// Echo width to distance conversion with saturation
`default_nettype none

module uer_dist (
  input  wire logic [31:0] width_us,
  input  wire logic [15:0] max_mm,
  output logic [15:0]      dist_mm
);
  import uer_pkg::*;

  logic [31:0]        scaled;
  logic [27:0]        dividend;
  logic [56:0]        prod;
  logic [QUO_W-1:0]   quo;

  // width * 343 as shift-add, wrapping at 32 bits (343 = 256+64+16+4+2+1)
  assign scaled = (width_us << 8) + (width_us << 6) + (width_us << 4)
                + (width_us << 2) + (width_us << 1) + width_us;

  // divide by 16 then by 125 through the reciprocal
  assign dividend = scaled[31:4];
  assign prod     = 57'(dividend) * 57'(DIV_RECIP);
  assign quo      = prod[DIV_SHIFT+QUO_W-1:DIV_SHIFT];

  // saturate at the configured limit
  assign dist_mm = (quo > QUO_W'(max_mm)) ? max_mm : quo[15:0];

endmodule

`default_nettype wire

@@ rtl/uer_core.sv @@
// Measurement state and per-word result logic of the echo ranger
`default_nettype none
`include "assert_macros.svh"

module uer_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire uer_pkg::item_t   item,
  input  wire uer_pkg::cfg_t    cfg,
  output uer_pkg::result_t      res
);
  import uer_pkg::*;

  logic        measuring, measuring_next;
  logic        awaiting_fall, awaiting_fall_next;
  logic        owner_line, owner_line_next;
  logic        have_result, have_result_next;
  logic [31:0] start_ms, start_ms_next;
  logic [31:0] rise_us, rise_us_next;
  logic [31:0] echo_ms, echo_ms_next;
  logic [15:0] stored_mm, stored_mm_next;

  logic [31:0] run_ms;
  logic [31:0] echo_age_ms;
  logic [15:0] dist_mm;
  logic        started;

  uer_dist u_dist (
    .width_us (item.now_us - rise_us),
    .max_mm   (cfg.max_distance_mm),
    .dist_mm  (dist_mm)
  );

  assign run_ms = item.now_ms - start_ms;

  // next state for the word in the input stage
  always_comb begin
    measuring_next     = measuring;
    awaiting_fall_next = awaiting_fall;
    owner_line_next    = owner_line;
    have_result_next   = have_result;
    start_ms_next      = start_ms;
    rise_us_next       = rise_us;
    echo_ms_next       = echo_ms;
    stored_mm_next     = stored_mm;
    started            = 1'b0;
    case (item.func)
      FUNC_TRIGGER: begin
        // young active measurement: leave it alone
        if (!(measuring && (run_ms < {16'd0, cfg.echo_timeout_ms}))) begin
          if (measuring) begin
            // stale run also drops the stored distance
            have_result_next = 1'b0;
            owner_line_next  = 1'b0;
          end
          measuring_next     = 1'b1;
          awaiting_fall_next = 1'b0;
          start_ms_next      = item.now_ms;
          started            = 1'b1;
        end
      end
      FUNC_EDGE: begin
        if (measuring) begin
          if (item.echo_level) begin
            // rising edge, unless the other line owns the echo
            if (!(awaiting_fall && (owner_line != item.echo_line))) begin
              rise_us_next       = item.now_us;
              awaiting_fall_next = 1'b1;
              owner_line_next    = item.echo_line;
            end
          end else if (awaiting_fall && (owner_line == item.echo_line)) begin
            stored_mm_next     = dist_mm;
            echo_ms_next       = item.now_ms;
            have_result_next   = 1'b1;
            measuring_next     = 1'b0;
            awaiting_fall_next = 1'b0;
            owner_line_next    = 1'b0;
          end
        end
      end
      FUNC_POLL: ;
      default: ;
    endcase
  end

  // result fields from the updated state
  assign echo_age_ms = item.now_ms - echo_ms_next;
  always_comb begin
    res.distance_mm    = have_result_next ? stored_mm_next : 16'd0;
    res.distance_valid = have_result_next;
    res.distance_fresh = have_result_next && (echo_age_ms <= {16'd0, cfg.fresh_window_ms});
    res.pulse_started  = started;
    res.busy_res       = measuring_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      measuring     <= 1'b0;
      awaiting_fall <= 1'b0;
      owner_line    <= 1'b0;
      have_result   <= 1'b0;
    end else if (step) begin
      measuring     <= measuring_next;
      awaiting_fall <= awaiting_fall_next;
      owner_line    <= owner_line_next;
      have_result   <= have_result_next;
    end
  end

  // timestamps and distance
  always_ff @(posedge clk) begin
    if (step) begin
      start_ms  <= start_ms_next;
      rise_us   <= rise_us_next;
      echo_ms   <= echo_ms_next;
      stored_mm <= stored_mm_next;
    end
  end

  `UER_ASSERT_ALWAYS(a_await_needs_run, awaiting_fall |-> measuring, "awaiting fall while idle")
  `UER_ASSERT(a_start_sets_run, step && started |=> measuring, "started pulse left block idle")
  `UER_ASSERT(a_result_ends_run, $rose(have_result) |-> $past(measuring) && !measuring,
    "distance stored outside a measurement")

endmodule

`default_nettype wire

@@ rtl/ultrasonic_echo_ranger_top.sv @@
// Ultrasonic echo ranger: one result word for each accepted input word.
// A taken word goes from the input register to the result register on the master side.
// One word per cycle unless m_axis_tready stalls; state and result register update together.
// Reset (rst, synchronous, active high) clears the measurement state and both stages and
// loads the configuration defaults (timeout 60 ms, fresh window 200 ms, limit 4000 mm).
`default_nettype none
`include "assert_macros.svh"

module ultrasonic_echo_ranger_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // stream input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // echo_level, now_ms, now_us, zero fill
  input  wire logic [2:0]  s_axis_tuser,   // func[1:0], echo_line
  // stream output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // distance_mm[15:0], distance_valid,
                                           // distance_fresh, pulse_started, busy_res, zero fill
  // configuration write
  input  wire logic        cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  import uer_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t res;
  cfg_t    cfg;
  logic    step;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // word moves from input register to result register
  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.func       <= func_t'(s_axis_tuser[1:0]);
      in_item.echo_line  <= s_axis_tuser[2];
      in_item.echo_level <= s_axis_tdata[0];
      in_item.now_ms     <= s_axis_tdata[32:1];
      in_item.now_us     <= s_axis_tdata[64:33];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_res.busy_res, out_res.pulse_started,
                          out_res.distance_fresh, out_res.distance_valid,
                          out_res.distance_mm};

  `UER_ASSERT(a_stall_only_when_full, !s_axis_tready |-> in_valid && out_valid && !m_axis_tready,
    "input stalled with room in the pipeline")
  `UER_ASSERT(a_start_reports_busy, out_valid && out_res.pulse_started |-> out_res.busy_res,
    "started measurement not reported busy")

endmodule

`default_nettype wire
